@@ hdl/hrd_pkg.sv @@
// Shared types, constants and register codes for the heartbeat rate detector.
package hrd_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned TIME_WIDTH_DEF   = 32;

  localparam logic [15:0] BPM_NUMERATOR = 16'd60000;
  localparam int unsigned DIV_STEPS     = 16;
  localparam int unsigned DIV_CNT_W     = $clog2(DIV_STEPS);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam logic signed [15:0] THRESHOLD_RST = 16'sd2000;
  localparam logic [15:0]        GAP_RST       = 16'd600;
  localparam logic [7:0]         NO_BEAT_RST   = 8'd99;

  localparam logic [1:0] CFG_TRIG_LEVEL      = 2'd0;
  localparam logic [1:0] CFG_MIN_PEAK_GAP_MS = 2'd1;
  localparam logic [1:0] CFG_NO_BEAT_CODE    = 2'd2;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic [15:0] rate_bpm;
    logic        beat;
  } out_t;

  typedef struct packed {
    logic signed [15:0] trig_level;
    logic [15:0]        min_peak_gap_ms;
    logic [7:0]         no_beat_code;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic pop;
    logic load;
  } bk_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } bk_state_e;

endpackage

@@ hdl/hrd_front.sv @@
// Front end: accepts samples, compares them against the threshold, pushes requests.
module hrd_front import hrd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_i,
  input  cfg_t                  cfg_i,
  input  q_stat_t               q_stat_i,
  output logic                  push_o,
  output logic [TIME_WIDTH:0]   push_data_o
);

  localparam int unsigned EXT_W = ((SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16) + 1;

  logic [EXT_W-1:0]        raw;
  logic signed [EXT_W-1:0] samp_sx;
  logic signed [EXT_W-1:0] thr_sx;
  logic                    above;

  assign raw     = EXT_W'(unsigned'(in_i.sample));
  assign samp_sx = EXT_W'(signed'(raw[SAMPLE_WIDTH-1:0]));
  assign thr_sx  = EXT_W'(cfg_i.trig_level);
  assign above   = samp_sx > thr_sx;

  assign in_stall_o  = q_stat_i.full;
  assign push_o      = in_valid_i && !q_stat_i.full;
  assign push_data_o = {above, in_i.time_ms[TIME_WIDTH-1:0]};

endmodule

@@ hdl/hrd_queue.sv @@
// Two-entry request queue between front end and back end.
module hrd_queue import hrd_pkg::*; #(
  parameter int unsigned DW = TIME_WIDTH_DEF + 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o,
  output q_stat_t       stat_o
);

  logic [DW-1:0]  mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;

  assign stat_o.full  = cnt_q == (QAW+1)'(QDEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/hrd_back.sv @@
// Back end: peak gating, bit-serial rate divider, held state and output register.
module hrd_back import hrd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  q_stat_t             q_stat_i,
  input  logic [TIME_WIDTH:0] q_data_i,
  output logic                pop_o,
  output bk_stat_t            stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_o
);

  bk_state_e             state_q, state_d;
  logic [TIME_WIDTH-1:0] last_peak_q;
  logic [15:0]           held_rate_q;
  logic [15:0]           quo_q, quo_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [TIME_WIDTH-1:0] div_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  out_valid_q;
  out_t                  out_q;

  logic                  above;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  gap_ok;
  logic                  slot_ok;
  logic                  take;
  logic                  div_start;
  logic                  div_last;
  logic [TIME_WIDTH:0]   shifted;
  logic [TIME_WIDTH:0]   trial;
  logic                  load;
  out_t                  res;

  assign above     = q_data_i[TIME_WIDTH];
  assign now       = q_data_i[TIME_WIDTH-1:0];
  assign elapsed   = now - last_peak_q;
  assign gap_ok    = elapsed > TIME_WIDTH'(cfg_i.min_peak_gap_ms);
  assign slot_ok   = !out_valid_q || !out_stall_i;
  assign take      = (state_q == BK_IDLE) && !q_stat_i.empty && slot_ok;
  assign div_start = take && above && gap_ok;
  assign div_last  = cnt_q == DIV_CNT_W'(DIV_STEPS - 1);

  assign shifted = {rem_q, quo_q[15]};
  assign trial   = shifted - {1'b0, div_q};

  always_comb begin
    if (!trial[TIME_WIDTH]) begin
      rem_d = trial[TIME_WIDTH-1:0];
      quo_d = {quo_q[14:0], 1'b1};
    end else begin
      rem_d = shifted[TIME_WIDTH-1:0];
      quo_d = {quo_q[14:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (div_start) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (div_last) begin
          state_d = BK_FIN;
        end
      end
      BK_FIN: begin
        if (slot_ok) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    load = 1'b0;
    res  = '0;
    case (state_q)
      BK_IDLE: begin
        if (take && !above) begin
          load         = 1'b1;
          res.rate_bpm = 16'(cfg_i.no_beat_code);
        end else if (take && !gap_ok) begin
          load         = 1'b1;
          res.rate_bpm = held_rate_q;
        end
      end
      BK_FIN: begin
        if (slot_ok) begin
          load         = 1'b1;
          res.rate_bpm = quo_q;
          res.beat     = 1'b1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign pop_o       = take;
  assign stat_o      = '{busy: state_q != BK_IDLE, pop: take, load: load};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      last_peak_q <= '0;
      held_rate_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (div_start) begin
        last_peak_q <= now;
        cnt_q       <= '0;
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (load) begin
        held_rate_q <= res.rate_bpm;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      quo_q <= BPM_NUMERATOR;
      rem_q <= '0;
      div_q <= elapsed;
    end else if (state_q == BK_DIV) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (load) begin
      out_q <= res;
    end
  end

endmodule

@@ hdl/heartbeat_rate_detector_core.sv @@
// With no beat found, a request is registered in the queue and then in the output register.
// Throughput: one request per cycle at or below threshold or inside the gap window, while the output is not stalled.
// A new peak holds the back end in BK_DIV for the 16-step bit-serial rate divider, then in BK_FIN.
// A two-entry queue lets the front end keep taking requests during a division.
// Reset (async, active low) loads the threshold, gap and no-beat defaults and clears peak state.
module heartbeat_rate_detector_core import hrd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned TIME_WIDTH   = TIME_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t                cfg_q;
  q_stat_t             q_stat;
  bk_stat_t            bk_stat;
  logic                push;
  logic [TIME_WIDTH:0] push_data;
  logic                pop;
  logic [TIME_WIDTH:0] pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.trig_level      <= THRESHOLD_RST;
      cfg_q.min_peak_gap_ms <= GAP_RST;
      cfg_q.no_beat_code    <= NO_BEAT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TRIG_LEVEL:      cfg_q.trig_level      <= signed'(cfg_data_i);
        CFG_MIN_PEAK_GAP_MS: cfg_q.min_peak_gap_ms <= cfg_data_i;
        CFG_NO_BEAT_CODE:    cfg_q.no_beat_code    <= cfg_data_i[7:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  hrd_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  hrd_queue #(
    .DW(TIME_WIDTH + 1)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  hrd_back #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_stat_i   (q_stat),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .stat_o     (bk_stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

`ifndef SYNTHESIS
  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.busy |-> !bk_stat.pop)
    else $error("back end popped a request during a division");

  a_queue_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_result_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bk_stat.load))
    else $error("result appeared without an output load");

  a_pop_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.pop |-> !q_stat.empty)
    else $error("pop from an empty queue");
`endif

endmodule

@@ dv/tb_heartbeat_rate_detector_core.sv @@
// Testbench for the heartbeat rate detector core: directed and random requests.
`timescale 1ns / 100ps

module tb_heartbeat_rate_detector_core;
  import hrd_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned SEGMENTS      = 8;
  localparam int unsigned SEG_REQUESTS  = 70;
  localparam logic [31:0] RATE_DIVIDEND = 32'd60000;
  localparam logic [1:0]  CFG_UNUSED    = 2'd3;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_t         in_i        = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;

  logic signed [15:0] thr_q;
  logic [15:0]        gap_q;
  logic [7:0]         code_q;
  logic [31:0]        last_peak_q;
  logic [15:0]        held_rate_q;

  out_t        pending_rates[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned idle_pct     = 0;
  int unsigned stall_pct    = 0;
  logic [31:0] clock_ms;

  heartbeat_rate_detector_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic out_t predict_rate(input in_t req);
    out_t        res;
    logic [31:0] elapsed;
    logic [31:0] quot;
    res.beat = 1'b0;
    if ($signed(req.sample) > $signed(thr_q)) begin
      elapsed = req.time_ms - last_peak_q;
      if (elapsed > {16'd0, gap_q}) begin
        quot        = RATE_DIVIDEND / elapsed;
        held_rate_q = quot[15:0];
        last_peak_q = req.time_ms;
        res.beat    = 1'b1;
      end
    end else begin
      held_rate_q = {8'd0, code_q};
    end
    res.rate_bpm = held_rate_q;
    return res;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rates.size() == 0) begin
        report_mismatch($sformatf("unexpected result rate=%0d beat=%0b",
                                  out_o.rate_bpm, out_o.beat));
      end else begin
        want = pending_rates.pop_front();
        if (out_o.rate_bpm !== want.rate_bpm)
          report_mismatch($sformatf("rate_bpm got %0d want %0d",
                                    out_o.rate_bpm, want.rate_bpm));
        if (out_o.beat !== want.beat)
          report_mismatch($sformatf("beat got %0b want %0b", out_o.beat, want.beat));
      end
    end
  end

  task automatic send_sample(input logic signed [15:0] smp, input logic [31:0] tms);
    in_t req;
    req.sample  = smp;
    req.time_ms = tms;
    in_i       <= req;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_rates.push_back(predict_rate(req));
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_results();
    if (in_valid_i) in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rates.size() != 0);
  endtask

  task automatic program_cfg(input logic [15:0] thr, input logic [15:0] gap,
                             input logic [15:0] code);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    idx = '{CFG_UNUSED, CFG_TRIG_LEVEL, CFG_MIN_PEAK_GAP_MS, CFG_NO_BEAT_CODE};
    val = '{16'($urandom), thr, gap, code};
    cfg_valid_i <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (idx[i])
        CFG_TRIG_LEVEL:      thr_q  = val[i];
        CFG_MIN_PEAK_GAP_MS: gap_q  = val[i];
        CFG_NO_BEAT_CODE:    code_q = val[i][7:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(input bit above);
    int thr;
    thr = $signed(thr_q);
    if (above && thr < 32767)
      return 16'(thr + 1 + int'($urandom_range(32766 - thr)));
    return 16'(-32768 + int'($urandom_range(thr + 32768)));
  endfunction

  task automatic test_threshold_edges();
    send_sample(16'sd2000, 32'd100);
    send_sample(16'sd2001, 32'd600);
    send_sample(16'sd2001, 32'd601);
    send_sample(16'sd32767, 32'd1201);
    send_sample(-16'sd32768, 32'd1300);
    send_sample(16'sd32767, 32'd1302);
    send_sample(16'sd0, 32'd1400);
  endtask

  task automatic test_time_wrap();
    send_sample(16'sd30000, 32'hFFFF_FFFF);
    send_sample(16'sd30000, 32'd0);
    send_sample(16'sd30000, 32'd601);
    send_sample(16'sd30000, 32'd300);
    send_sample(16'sd30000, 32'd1000);
    wait_results();
  endtask

  task automatic test_config_extremes();
    program_cfg(16'h8000, 16'd0, 16'hFF00);
    send_sample(-16'sd32768, 32'd1000);
    send_sample(-16'sd32767, 32'd1000);
    send_sample(-16'sd32767, 32'd1001);
    send_sample(16'sd100, 32'd1002);
    wait_results();
    program_cfg(16'h7FFF, 16'hFFFF, 16'h00FF);
    send_sample(16'sd32767, 32'd5000);
    send_sample(-16'sd1, 32'd5001);
    wait_results();
    program_cfg(16'd100, 16'hFFFF, 16'h55AA);
    send_sample(16'sd101, 32'd1002 + 32'd65535);
    send_sample(16'sd101, 32'd1002 + 32'd65536);
    wait_results();
  endtask

  task automatic test_random_traffic();
    logic [15:0] thr;
    logic [15:0] gap;
    logic [31:0] step_ms;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_results();
      idle_pct  = (seg % 4 == 1) ? 53 : (seg % 4 == 3) ? 10 : 0;
      stall_pct = (seg % 4 == 2) ? 53 : (seg % 4 == 3) ? 10 : 0;
      thr = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4000) - 1000);
      case ($urandom_range(9))
        0:       gap = 16'd0;
        1:       gap = 16'($urandom);
        default: gap = 16'($urandom_range(1000));
      endcase
      program_cfg(thr, gap, 16'($urandom));
      clock_ms = (seg == 3) ? 32'hFFFF_FF00 : $urandom;
      for (int n = 0; n < SEG_REQUESTS; n++) begin
        if ($urandom_range(9) == 0) begin
          send_sample(16'($urandom), $urandom);
        end else begin
          step_ms   = $urandom_range(gap_q / 2 + 50, 1);
          clock_ms += step_ms;
          send_sample(pick_sample($urandom_range(99) < 55), clock_ms);
        end
        if ($urandom_range(59) == 0) wait_results();
      end
    end
  endtask

  initial begin
    thr_q       = THRESHOLD_RST;
    gap_q       = GAP_RST;
    code_q      = NO_BEAT_RST;
    last_peak_q = '0;
    held_rate_q = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_threshold_edges();
    test_time_wrap();
    test_config_extremes();
    test_random_traffic();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_rates.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_rates.size()));
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
